// ----- rtl/hamc_pkg.sv -----
// shared types and constants for the half-precision alpha matte compositor
`timescale 1ns / 1ps
package hamc_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned FracBits = 24;
  localparam int unsigned NumCh    = 3;

  localparam logic [4:0] ExpMax  = 5'h1F;
  localparam logic [4:0] ExpOne  = 5'd15;

  // configuration register indexes
  localparam logic [1:0] CFG_BG_C0 = 2'd0;
  localparam logic [1:0] CFG_BG_C1 = 2'd1;
  localparam logic [1:0] CFG_BG_C2 = 2'd2;

  localparam logic [ChW-1:0] BG_C0_RST = 8'd0;
  localparam logic [ChW-1:0] BG_C1_RST = 8'd255;
  localparam logic [ChW-1:0] BG_C2_RST = 8'd0;

  typedef enum logic [1:0] {
    MODE_BG,
    MODE_FG,
    MODE_MIX
  } mode_e;

  typedef logic [NumCh-1:0][ChW-1:0] pixel_t;

  typedef struct packed {
    mode_e               mode;
    logic [FracBits-1:0] alpha_fx;
  } decode_t;

  typedef struct packed {
    logic s2_en;
    logic s3_en;
  } stage_en_t;

endpackage

// ----- rtl/hamc_decode.sv -----
// stage 1: half-precision alpha decode to 24-bit fixed point plus blend mode
`timescale 1ns / 1ps
module hamc_decode (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [15:0]              alpha_half_i,
  input  hamc_pkg::pixel_t         fg_i,
  output hamc_pkg::decode_t        dec_o,
  output hamc_pkg::pixel_t         fg_o
);

  logic                          sign;
  logic [4:0]                    ex;
  logic [9:0]                    fr;
  logic                          is_nan;
  logic                          is_zero;
  logic [hamc_pkg::FracBits-1:0] mant;
  hamc_pkg::decode_t             dec_d, dec_q;
  hamc_pkg::pixel_t              fg_q;

  assign sign    = alpha_half_i[15];
  assign ex      = alpha_half_i[14:10];
  assign fr      = alpha_half_i[9:0];
  assign is_nan  = (ex == hamc_pkg::ExpMax) && (fr != 10'd0);
  assign is_zero = (ex == 5'd0) && (fr == 10'd0);
  assign mant    = {13'd0, 1'b1, fr};

  always_comb begin
    dec_d.mode     = hamc_pkg::MODE_BG;
    dec_d.alpha_fx = '0;
    if (is_nan || sign || is_zero) begin
      dec_d.mode = hamc_pkg::MODE_BG;
    end else if (ex >= hamc_pkg::ExpOne) begin
      dec_d.mode = hamc_pkg::MODE_FG;
    end else begin
      dec_d.mode = hamc_pkg::MODE_MIX;
      // subnormal keeps the raw fraction, normal gets the hidden one
      if (ex == 5'd0) begin
        dec_d.alpha_fx = {14'd0, fr};
      end else begin
        dec_d.alpha_fx = mant << (ex - 5'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
      fg_q  <= fg_i;
    end
  end

  assign dec_o = dec_q;
  assign fg_o  = fg_q;

endmodule

// ----- rtl/hamc_mix_lane.sv -----
// stages 2 and 3 of one color channel: weighted products, then sum and select
`timescale 1ns / 1ps
module hamc_mix_lane (
  input  logic                         clk_i,
  input  hamc_pkg::stage_en_t          en_i,
  input  hamc_pkg::decode_t            dec_i,
  input  logic [hamc_pkg::ChW-1:0]     fg_i,
  input  logic [hamc_pkg::ChW-1:0]     bg_i,
  output logic [hamc_pkg::ChW-1:0]     out_o
);

  localparam int unsigned ProdW = hamc_pkg::ChW + hamc_pkg::FracBits;

  logic [hamc_pkg::FracBits-1:0] inv_a;
  logic [ProdW-1:0]              p_fg_d, p_fg_q;
  logic [ProdW-1:0]              p_bg_d, p_bg_q;
  logic [ProdW-1:0]              sum;
  hamc_pkg::mode_e               mode_q;
  logic [hamc_pkg::ChW-1:0]      fg_q;
  logic [hamc_pkg::ChW-1:0]      out_d, out_q;

  // alpha is nonzero in mix mode, so 2^24 - alpha fits in 24 bits
  assign inv_a  = (~dec_i.alpha_fx) + 1'b1;
  assign p_fg_d = ProdW'(fg_i) * ProdW'(dec_i.alpha_fx);
  assign p_bg_d = ProdW'(bg_i) * ProdW'(inv_a);

  always_ff @(posedge clk_i) begin
    if (en_i.s2_en) begin
      p_fg_q <= p_fg_d;
      p_bg_q <= p_bg_d;
      mode_q <= dec_i.mode;
      fg_q   <= fg_i;
    end
  end

  // convex mix of two bytes never exceeds 255 * 2^24
  assign sum = p_fg_q + p_bg_q;

  always_comb begin
    case (mode_q)
      hamc_pkg::MODE_FG:  out_d = fg_q;
      hamc_pkg::MODE_MIX: out_d = sum[ProdW-1:hamc_pkg::FracBits];
      default:            out_d = bg_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3_en) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ----- rtl/half_alpha_matte_composite.sv -----
// top level of the half-precision alpha matte compositor
`timescale 1ns / 1ps
// Composites one pixel per clock: alpha (IEEE half) selects background for
// zero, negative or NaN, foreground for alpha >= 1, and otherwise blends
// bg + alpha*(fg - bg) exactly in 24-bit fixed point, truncated. Three
// register stages (decode, multiply, sum/select) lie between input transfer
// and output valid; with the output side ready the block takes one pixel
// every cycle, and a stall holds every stage without losing data. The user
// must write background registers through the cfg port only while the
// pipeline is empty, not enforced by the block; cfg_ready_o is always high.
module half_alpha_matte_composite (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // alpha_half[15:0], fg_c0, fg_c1, fg_c2
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // out_c0[7:0], out_c1, out_c2
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic                          v1_q, v2_q, v3_q;
  logic                          rdy1, rdy2, rdy3;
  logic                          en1;
  hamc_pkg::stage_en_t           lane_en;
  hamc_pkg::pixel_t              fg_in;
  hamc_pkg::pixel_t              fg_s1;
  hamc_pkg::pixel_t              bg_q;
  hamc_pkg::pixel_t              out_px;
  hamc_pkg::decode_t             dec_s1;

  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign en1  = rdy1 && s_axis_tvalid_i;

  assign lane_en.s2_en = rdy2 && v1_q;
  assign lane_en.s3_en = rdy3 && v2_q;

  assign s_axis_tready_o = rdy1;
  assign m_axis_tvalid_o = v3_q;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q[0] <= hamc_pkg::BG_C0_RST;
      bg_q[1] <= hamc_pkg::BG_C1_RST;
      bg_q[2] <= hamc_pkg::BG_C2_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hamc_pkg::CFG_BG_C0: bg_q[0] <= cfg_data_i;
        hamc_pkg::CFG_BG_C1: bg_q[1] <= cfg_data_i;
        hamc_pkg::CFG_BG_C2: bg_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fg_in[0] = s_axis_tdata_i[23:16];
  assign fg_in[1] = s_axis_tdata_i[31:24];
  assign fg_in[2] = s_axis_tdata_i[39:32];

  hamc_decode u_decode (
    .clk_i        (clk_i),
    .en_i         (en1),
    .alpha_half_i (s_axis_tdata_i[15:0]),
    .fg_i         (fg_in),
    .dec_o        (dec_s1),
    .fg_o         (fg_s1)
  );

  for (genvar c = 0; c < hamc_pkg::NumCh; c++) begin : g_lane
    hamc_mix_lane u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .dec_i (dec_s1),
      .fg_i  (fg_s1[c]),
      .bg_i  (bg_q[c]),
      .out_o (out_px[c])
    );
  end

  assign m_axis_tdata_o = {out_px[2], out_px[1], out_px[0]};

endmodule

// ----- rtl/hamc_checker.sv -----
// port-level checker for the compositor, bound to the top level
`timescale 1ns / 1ps
module hamc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [39:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // stalled output transfer holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  // an empty output stage means every stage can advance
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input not ready with output stage empty");

  // alpha of exactly one passes the foreground through to the output
  a_one_passes_fg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && s_axis_tdata_i[15:0] == 16'h3C00 ##1 m_axis_tready_i ##1 m_axis_tready_i
    |=> m_axis_tvalid_o && m_axis_tdata_o == $past(s_axis_tdata_i[39:16], 3))
    else $error("foreground not passed for alpha one");

endmodule

bind half_alpha_matte_composite hamc_checker u_hamc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/tb.sv -----
// testbench for the half-precision alpha matte compositor
`timescale 1ns / 1ps
module tb;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseItems    = 450;
  localparam logic [1:0]  CfgIdxUnused  = 2'd3;

  // alpha corner values: signed zeros, subnormal and normal edges, one, inf, nan
  localparam int unsigned NumEdge = 19;
  localparam logic [15:0] EdgeAlphas [NumEdge] = '{
    16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400, 16'h0200, 16'h3800,
    16'h3BFF, 16'h3C00, 16'h3C01, 16'h7BFF, 16'h7C00, 16'hFC00, 16'h7C01,
    16'h7E00, 16'hFFFF, 16'hBC00, 16'h8001, 16'h2E66
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned err_count     = 0;
  int unsigned idle_cycles   = 0;

  hamc_pkg::pixel_t bg_color = {hamc_pkg::BG_C2_RST, hamc_pkg::BG_C1_RST, hamc_pkg::BG_C0_RST};
  hamc_pkg::pixel_t pending_pixels[$];
  hamc_pkg::pixel_t oldest_pixel;

  half_alpha_matte_composite u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // composite of one pixel against the current background color
  function automatic hamc_pkg::pixel_t composite_pixel(input logic [15:0] alpha,
                                                       input hamc_pkg::pixel_t fg);
    logic                          sgn;
    logic [4:0]                    ex;
    logic [9:0]                    fr;
    logic [hamc_pkg::FracBits-1:0] alpha_fx;
    logic [63:0]                   acc;
    hamc_pkg::pixel_t              res;
    sgn = alpha[15];
    ex  = alpha[14:10];
    fr  = alpha[9:0];
    if ((ex == hamc_pkg::ExpMax && fr != '0) || sgn || (ex == '0 && fr == '0)) begin
      res = bg_color;
    end else if (ex >= hamc_pkg::ExpOne) begin
      res = fg;
    end else begin
      if (ex == '0) alpha_fx = hamc_pkg::FracBits'(fr);
      else alpha_fx = hamc_pkg::FracBits'({1'b1, fr}) << (ex - 5'd1);
      for (int c = 0; c < hamc_pkg::NumCh; c++) begin
        acc = 64'(bg_color[c]) * ((64'd1 << hamc_pkg::FracBits) - 64'(alpha_fx))
            + 64'(fg[c]) * 64'(alpha_fx);
        res[c] = acc[hamc_pkg::FracBits +: hamc_pkg::ChW];
      end
    end
    return res;
  endfunction

  // mix of alpha classes, weighted toward the blend range
  function automatic logic [15:0] rand_alpha();
    int unsigned pick;
    logic [4:0]  ex;
    pick = $urandom_range(99);
    if (pick < 55) begin
      ex = 5'($urandom_range(14));
      return {1'b0, ex, 10'($urandom)};
    end else if (pick < 70) begin
      ex = 5'($urandom_range(30, 15));
      return {1'b0, ex, 10'($urandom)};
    end else if (pick < 82) begin
      return {1'b1, 15'($urandom)};
    end else if (pick < 86) begin
      return {1'($urandom), 15'h0000};
    end else if (pick < 90) begin
      return {1'($urandom), hamc_pkg::ExpMax, 10'h000};
    end else if (pick < 94) begin
      return {1'($urandom), hamc_pkg::ExpMax, 10'($urandom_range(1023, 1))};
    end
    return 16'($urandom);
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic send_pixel(input logic [15:0] alpha, input hamc_pkg::pixel_t fg);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {fg, alpha};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_pixels = {pending_pixels, composite_pixel(alpha, fg)};
  endtask

  // stop sending and let the pipeline empty
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_bg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      hamc_pkg::CFG_BG_C0: bg_color[0] = val;
      hamc_pkg::CFG_BG_C1: bg_color[1] = val;
      hamc_pkg::CFG_BG_C2: bg_color[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_background(input hamc_pkg::pixel_t color);
    write_bg(hamc_pkg::CFG_BG_C0, color[0]);
    write_bg(hamc_pkg::CFG_BG_C1, color[1]);
    write_bg(hamc_pkg::CFG_BG_C2, color[2]);
  endtask

  // corner alphas against the reset background
  task automatic test_special_alphas();
    hamc_pkg::pixel_t fg;
    for (int i = 0; i < NumEdge; i++) begin
      case (i % 3)
        0: fg = {8'hFF, 8'hFF, 8'hFF};
        1: fg = {8'h00, 8'h00, 8'h00};
        default: fg = {8'hFF, 8'h00, 8'hA5};
      endcase
      send_pixel(EdgeAlphas[i], fg);
    end
    drain();
  endtask

  // background register extremes and a write to the unused index
  task automatic test_background_regs();
    set_background({8'hFF, 8'hFF, 8'hFF});
    send_pixel(16'h3800, {8'h00, 8'h00, 8'h00});
    send_pixel(16'hBC00, {8'h00, 8'h00, 8'h00});
    drain();
    set_background({8'h00, 8'h00, 8'h00});
    write_bg(CfgIdxUnused, 8'hAA);
    send_pixel(16'h3BFF, {8'hFF, 8'hFF, 8'hFF});
    send_pixel(16'h0001, {8'hFF, 8'hFF, 8'hFF});
    send_pixel(16'h7E00, {8'hFF, 8'hFF, 8'hFF});
    drain();
  endtask

  task automatic test_random_phase(input hamc_pkg::pixel_t color, input int unsigned src_pct,
                                   input int unsigned sink_pct);
    set_background(color);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < PhaseItems; i++) begin
      send_pixel(rand_alpha(), hamc_pkg::pixel_t'($urandom));
    end
    drain();
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected result %h", m_axis_tdata_o));
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        for (int c = 0; c < hamc_pkg::NumCh; c++) begin
          if (m_axis_tdata_o[hamc_pkg::ChW*c +: hamc_pkg::ChW] !== oldest_pixel[c])
            flag_error($sformatf("out_c%0d expected %h got %h",
                                 c, oldest_pixel[c],
                                 m_axis_tdata_o[hamc_pkg::ChW*c +: hamc_pkg::ChW]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_alphas();
    test_background_regs();
    test_random_phase(hamc_pkg::pixel_t'($urandom), 0, 0);
    test_random_phase({8'hFF, 8'h00, 8'hFF}, 81, 0);
    test_random_phase(hamc_pkg::pixel_t'($urandom), 0, 81);
    test_random_phase({8'h00, 8'hFF, 8'h00}, 7, 7);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
